// ===== rtl/event_handler_slot_table_core_assert.svh =====
// assertion macros for the slot table port checker
`ifndef EVENT_HANDLER_SLOT_TABLE_CORE_ASSERT_SVH
`define EVENT_HANDLER_SLOT_TABLE_CORE_ASSERT_SVH

// same-cycle implication, skipped while reset is high
`define EHT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, skipped while reset is high
`define EHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/eht_pkg.sv =====
// types, codes and defaults shared by the slot table modules
package eht_pkg;

   localparam int NUM_SIGNALS_DEF      = 16;
   localparam int SLOTS_PER_SIGNAL_DEF = 8;
   localparam int HANDLER_WIDTH_DEF    = 16;
   localparam int QUEUE_DEPTH          = 2;

   // widest signal count plus one, for the range check
   localparam int SIG_CMP_W = 9;

   typedef enum logic [1:0] {
      CMD_ADD     = 2'd0,
      CMD_REMOVE  = 2'd1,
      CMD_TRIGGER = 2'd2
   } command_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_FAIL         = 2'd1,
      ST_BAD_SIGNAL   = 2'd2,
      ST_ZERO_HANDLER = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      JOB_ADD,
      JOB_REMOVE,
      JOB_TRIGGER,
      JOB_BAD_SIGNAL,
      JOB_ZERO_HANDLER
   } job_kind_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_SCAN
   } back_state_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [3:0]  signal_number;
      logic [15:0] handler_id;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [2:0]  slot_index;
      logic [15:0] dispatched_handler;
      logic [3:0]  handler_count;
      logic        is_dispatch;
      logic        last;
   } rsp_type;

   typedef struct packed {
      job_kind_type kind;
      logic [3:0]   signal_number;
      logic [15:0]  handler_id;
   } job_type;

   function automatic rsp_type make_rsp(status_type status, logic [2:0] slot,
                                        logic [15:0] handler, logic [3:0] count,
                                        logic disp, logic last);
      rsp_type r;
      r.status             = status;
      r.slot_index         = slot;
      r.dispatched_handler = handler;
      r.handler_count      = count;
      r.is_dispatch        = disp;
      r.last               = last;
      return r;
   endfunction

endpackage

// ===== rtl/event_handler_slot_table_core.sv =====
// trigger: one slot memory read per cycle while no result is held up at the output
// add and remove: scan stops at the first matching slot
// bad signal and zero handler: a single error result from the sequencer, no table access
// a two-item queue lets the next request in while a row is being scanned
// after reset the table is zeroed one entry a cycle, all 2**(row bits + slot bits) entries
// (128 by default), with req_ready low throughout
module event_handler_slot_table_core #(
   parameter int NUM_SIGNALS      = eht_pkg::NUM_SIGNALS_DEF,
   parameter int SLOTS_PER_SIGNAL = eht_pkg::SLOTS_PER_SIGNAL_DEF,
   parameter int HANDLER_WIDTH    = eht_pkg::HANDLER_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  eht_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output eht_pkg::rsp_type rsp_data
);

   logic             push_valid, push_ready;
   eht_pkg::job_type push_job;
   logic             pop_valid, pop_ready;
   eht_pkg::job_type pop_job;
   logic             clearing;

   eht_front #(
      .NUM_SIGNALS   (NUM_SIGNALS),
      .HANDLER_WIDTH (HANDLER_WIDTH)
   ) u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .clearing   (clearing),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   eht_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   eht_back #(
      .NUM_SIGNALS      (NUM_SIGNALS),
      .SLOTS_PER_SIGNAL (SLOTS_PER_SIGNAL),
      .HANDLER_WIDTH    (HANDLER_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (pop_valid),
      .job_ready (pop_ready),
      .job       (pop_job),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/eht_queue.sv =====
// short job queue between the classifier and the table sequencer
module eht_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  eht_pkg::job_type push_job,
   output logic             pop_valid,
   input  logic             pop_ready,
   output eht_pkg::job_type pop_job
);

   localparam int DEPTH = eht_pkg::QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   eht_pkg::job_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/eht_front.sv =====
// request classifier: range and zero-handler checks, drops the unused command
module eht_front #(
   parameter int NUM_SIGNALS   = eht_pkg::NUM_SIGNALS_DEF,
   parameter int HANDLER_WIDTH = eht_pkg::HANDLER_WIDTH_DEF
) (
   input  logic             req_valid,
   output logic             req_ready,
   input  eht_pkg::req_type req_data,
   input  logic             clearing,
   output logic             push_valid,
   input  logic             push_ready,
   output eht_pkg::job_type push_job
);

   localparam logic [eht_pkg::SIG_CMP_W-1:0] SIG_LIMIT =
      eht_pkg::SIG_CMP_W'(NUM_SIGNALS);

   logic known_cmd;
   logic bad_signal;
   logic zero_handler;

   always_comb begin
      known_cmd    = (req_data.command inside {eht_pkg::CMD_ADD, eht_pkg::CMD_REMOVE,
                                               eht_pkg::CMD_TRIGGER});
      bad_signal   = (eht_pkg::SIG_CMP_W'(req_data.signal_number) >= SIG_LIMIT);
      zero_handler = (HANDLER_WIDTH'(req_data.handler_id) == '0);

      req_ready  = push_ready && !clearing;
      push_valid = req_valid && req_ready && known_cmd;

      push_job.signal_number = req_data.signal_number;
      push_job.handler_id    = req_data.handler_id;
      // range check wins over everything else
      if (bad_signal) begin
         push_job.kind = eht_pkg::JOB_BAD_SIGNAL;
      end else if (req_data.command == eht_pkg::CMD_TRIGGER) begin
         push_job.kind = eht_pkg::JOB_TRIGGER;
      end else if (zero_handler) begin
         push_job.kind = eht_pkg::JOB_ZERO_HANDLER;
      end else if (req_data.command == eht_pkg::CMD_ADD) begin
         push_job.kind = eht_pkg::JOB_ADD;
      end else begin
         push_job.kind = eht_pkg::JOB_REMOVE;
      end
   end

endmodule

// ===== rtl/eht_back.sv =====
// table sequencer: slot memory, row scan and result register
module eht_back #(
   parameter int NUM_SIGNALS      = eht_pkg::NUM_SIGNALS_DEF,
   parameter int SLOTS_PER_SIGNAL = eht_pkg::SLOTS_PER_SIGNAL_DEF,
   parameter int HANDLER_WIDTH    = eht_pkg::HANDLER_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             job_valid,
   output logic             job_ready,
   input  eht_pkg::job_type job,
   output logic             clearing,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output eht_pkg::rsp_type rsp_data
);

   localparam int ROW_W     = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1;
   localparam int SLOT_W    = (SLOTS_PER_SIGNAL > 1) ? $clog2(SLOTS_PER_SIGNAL) : 1;
   localparam int CNT_W     = $clog2(SLOTS_PER_SIGNAL + 1);
   localparam int ADDR_W    = ROW_W + SLOT_W;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam logic [CNT_W-1:0] SLOT_END = CNT_W'(SLOTS_PER_SIGNAL);

   logic [HANDLER_WIDTH-1:0] slot_table_ff [MEM_DEPTH];
   logic [HANDLER_WIDTH-1:0] rd_data_ff;

   eht_pkg::back_state_type state_ff, state_in;
   eht_pkg::job_kind_type   kind_ff, kind_in;
   logic [ROW_W-1:0]         row_ff, row_in;
   logic [HANDLER_WIDTH-1:0] hid_ff, hid_in;
   logic [CNT_W-1:0]         slot_ff, slot_in;
   logic                     chk_valid_ff, chk_valid_in;
   logic [SLOT_W-1:0]        chk_slot_ff, chk_slot_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [ADDR_W-1:0]        clr_ff, clr_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   eht_pkg::rsp_type         rsp_data_ff, rsp_data_in;

   logic                     mem_we, mem_re;
   logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
   logic [HANDLER_WIDTH-1:0] mem_wdata;
   logic                     out_free, load_rsp;
   logic                     hit, done_scan, stall;
   logic [ROW_W-1:0]         job_row;

   assign clearing  = (state_ff == eht_pkg::BK_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      row_in       = row_ff;
      hid_in       = hid_ff;
      slot_in      = slot_ff;
      chk_valid_in = chk_valid_ff;
      chk_slot_in  = chk_slot_ff;
      count_in     = count_ff;
      clr_in       = clr_ff;
      rsp_data_in  = rsp_data_ff;
      load_rsp     = 1'b0;
      job_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = {row_ff, chk_slot_ff};
      mem_wdata    = '0;
      mem_re       = 1'b0;
      mem_raddr    = {row_ff, slot_ff[SLOT_W-1:0]};
      job_row      = ROW_W'(job.signal_number);
      out_free     = !rsp_valid_ff || rsp_ready;

      // rd_data_ff holds the entry at chk_slot_ff when chk_valid_ff is set
      hit = 1'b0;
      if (chk_valid_ff) begin
         case (kind_ff)
            eht_pkg::JOB_ADD:     hit = (rd_data_ff == '0);
            eht_pkg::JOB_REMOVE:  hit = (rd_data_ff == hid_ff);
            eht_pkg::JOB_TRIGGER: hit = (rd_data_ff != '0);
            default:              hit = 1'b0;
         endcase
      end
      done_scan = !chk_valid_ff && (slot_ff == SLOT_END);
      stall     = (hit || done_scan) && !out_free;

      case (state_ff)
         eht_pkg::BK_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == '1) begin
               state_in = eht_pkg::BK_IDLE;
            end
         end
         eht_pkg::BK_IDLE: begin
            if (job_valid) begin
               if (job.kind inside {eht_pkg::JOB_BAD_SIGNAL, eht_pkg::JOB_ZERO_HANDLER}) begin
                  // single error result, no table access
                  if (out_free) begin
                     job_ready   = 1'b1;
                     load_rsp    = 1'b1;
                     rsp_data_in = eht_pkg::make_rsp(
                        (job.kind == eht_pkg::JOB_BAD_SIGNAL) ? eht_pkg::ST_BAD_SIGNAL
                                                              : eht_pkg::ST_ZERO_HANDLER,
                        3'd0, 16'd0, 4'd0, 1'b0, 1'b1);
                  end
               end else begin
                  job_ready    = 1'b1;
                  kind_in      = job.kind;
                  row_in       = job_row;
                  hid_in       = HANDLER_WIDTH'(job.handler_id);
                  mem_re       = 1'b1;
                  mem_raddr    = {job_row, SLOT_W'(0)};
                  chk_valid_in = 1'b1;
                  chk_slot_in  = '0;
                  slot_in      = CNT_W'(1);
                  count_in     = '0;
                  state_in     = eht_pkg::BK_SCAN;
               end
            end
         end
         eht_pkg::BK_SCAN: begin
            if (!stall) begin
               if (hit && kind_ff != eht_pkg::JOB_TRIGGER) begin
                  mem_we      = 1'b1;
                  mem_wdata   = (kind_ff == eht_pkg::JOB_ADD) ? hid_ff : '0;
                  load_rsp    = 1'b1;
                  rsp_data_in = eht_pkg::make_rsp(eht_pkg::ST_OK, 3'(chk_slot_ff),
                                                  16'd0, 4'd0, 1'b0, 1'b1);
                  state_in    = eht_pkg::BK_IDLE;
               end else if (done_scan) begin
                  load_rsp = 1'b1;
                  if (kind_ff == eht_pkg::JOB_TRIGGER) begin
                     rsp_data_in = eht_pkg::make_rsp(eht_pkg::ST_OK, 3'd0, 16'd0,
                                                     4'(count_ff), 1'b0, 1'b1);
                  end else begin
                     rsp_data_in = eht_pkg::make_rsp(eht_pkg::ST_FAIL, 3'd0, 16'd0,
                                                     4'd0, 1'b0, 1'b1);
                  end
                  state_in = eht_pkg::BK_IDLE;
               end else begin
                  if (hit) begin
                     load_rsp    = 1'b1;
                     rsp_data_in = eht_pkg::make_rsp(eht_pkg::ST_OK, 3'(chk_slot_ff),
                                                     16'(rd_data_ff), 4'd0, 1'b1, 1'b0);
                     count_in    = count_ff + CNT_W'(1);
                  end
                  // fetch the next slot of the row
                  if (slot_ff != SLOT_END) begin
                     mem_re       = 1'b1;
                     chk_valid_in = 1'b1;
                     chk_slot_in  = slot_ff[SLOT_W-1:0];
                     slot_in      = slot_ff + CNT_W'(1);
                  end else begin
                     chk_valid_in = 1'b0;
                  end
               end
            end
         end
         default: begin
            state_in = eht_pkg::BK_CLEAR;
         end
      endcase

      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= eht_pkg::BK_CLEAR;
         clr_ff       <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         slot_ff      <= '0;
         count_ff     <= '0;
         kind_ff      <= eht_pkg::JOB_ADD;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         slot_ff      <= slot_in;
         count_ff     <= count_in;
         kind_ff      <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      hid_ff      <= hid_in;
      chk_slot_ff <= chk_slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_table_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= slot_table_ff[mem_raddr];
      end
   end

endmodule

// ===== rtl/eht_checker.sv =====
// port checker for the slot table and its bind
`include "event_handler_slot_table_core_assert.svh"

module eht_port_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input eht_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input eht_pkg::rsp_type rsp_data
);

   `EHT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_data), "result changed while stalled")

   `EHT_ASSERT_NOW(a_dispatch_not_last, clock, reset, rsp_valid && rsp_data.is_dispatch,
      !rsp_data.last && rsp_data.status == eht_pkg::ST_OK &&
      rsp_data.dispatched_handler != 16'd0, "bad dispatch result")

   `EHT_ASSERT_NOW(a_plain_is_last, clock, reset, rsp_valid && !rsp_data.is_dispatch,
      rsp_data.last && rsp_data.dispatched_handler == 16'd0, "non-dispatch result not last")

   `EHT_ASSERT_NOW(a_count_on_final, clock, reset, rsp_valid && rsp_data.handler_count != 4'd0,
      rsp_data.last && rsp_data.status == eht_pkg::ST_OK && rsp_data.slot_index == 3'd0,
      "handler count outside final trigger result")

endmodule

bind event_handler_slot_table_core eht_port_checker u_checker (.*);

// ===== tb/sv/eht_checker.sv =====
// checker for the slot table: tracks the table, predicts every result and compares it
`timescale 1ns / 100ps
module eht_checker #(
   parameter int NUM_SIGNALS      = eht_pkg::NUM_SIGNALS_DEF,
   parameter int SLOTS_PER_SIGNAL = eht_pkg::SLOTS_PER_SIGNAL_DEF,
   parameter int HANDLER_WIDTH    = eht_pkg::HANDLER_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  eht_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  eht_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               awaited_count
);

   logic [HANDLER_WIDTH-1:0] slot_store [NUM_SIGNALS][SLOTS_PER_SIGNAL];
   eht_pkg::rsp_type         awaited_q[$];

   function automatic eht_pkg::rsp_type result_of(eht_pkg::status_type st,
                                                  int unsigned slot,
                                                  logic [63:0] handler,
                                                  int unsigned count,
                                                  logic disp, logic fin);
      eht_pkg::rsp_type r;
      r.status             = st;
      r.slot_index         = slot[2:0];
      r.dispatched_handler = handler[15:0];
      r.handler_count      = count[3:0];
      r.is_dispatch        = disp;
      r.last               = fin;
      return r;
   endfunction

   function automatic string fmt_rsp(eht_pkg::rsp_type r);
      return $sformatf("status=%0d slot=%0d handler=%h count=%0d dispatch=%b last=%b",
                       r.status, r.slot_index, r.dispatched_handler, r.handler_count,
                       r.is_dispatch, r.last);
   endfunction

   function automatic bit report_due();
      mismatch_count++;
      return mismatch_count <= 10;
   endfunction

   // updates the table copy and queues the results one request causes
   task automatic apply_command(eht_pkg::req_type item);
      logic [63:0] hid;
      int unsigned sig;
      int unsigned hits;
      bit          done;
      hid  = 64'(item.handler_id) & ((64'd1 << HANDLER_WIDTH) - 64'd1);
      sig  = item.signal_number;
      hits = 0;
      done = 1'b0;
      if (!(item.command inside {eht_pkg::CMD_ADD, eht_pkg::CMD_REMOVE,
                                 eht_pkg::CMD_TRIGGER}))
         return;
      if (sig >= NUM_SIGNALS) begin
         awaited_q.push_back(result_of(eht_pkg::ST_BAD_SIGNAL, 0, 0, 0, 1'b0, 1'b1));
         return;
      end
      if (item.command == eht_pkg::CMD_TRIGGER) begin
         for (int i = 0; i < SLOTS_PER_SIGNAL; i++) begin
            if (slot_store[sig][i] != '0) begin
               awaited_q.push_back(result_of(eht_pkg::ST_OK, i, 64'(slot_store[sig][i]), 0,
                                             1'b1, 1'b0));
               hits++;
            end
         end
         awaited_q.push_back(result_of(eht_pkg::ST_OK, 0, 0, hits, 1'b0, 1'b1));
         return;
      end
      if (hid == '0) begin
         awaited_q.push_back(result_of(eht_pkg::ST_ZERO_HANDLER, 0, 0, 0, 1'b0, 1'b1));
         return;
      end
      // lowest matching slot wins
      for (int i = 0; i < SLOTS_PER_SIGNAL; i++) begin
         if (!done) begin
            if (item.command == eht_pkg::CMD_ADD && slot_store[sig][i] == '0) begin
               slot_store[sig][i] = hid[HANDLER_WIDTH-1:0];
               done = 1'b1;
            end else if (item.command == eht_pkg::CMD_REMOVE &&
                         64'(slot_store[sig][i]) == hid) begin
               slot_store[sig][i] = '0;
               done = 1'b1;
            end
            if (done)
               awaited_q.push_back(result_of(eht_pkg::ST_OK, i, 0, 0, 1'b0, 1'b1));
         end
      end
      if (!done)
         awaited_q.push_back(result_of(eht_pkg::ST_FAIL, 0, 0, 0, 1'b0, 1'b1));
   endtask

   task automatic check_result(eht_pkg::rsp_type got);
      eht_pkg::rsp_type want;
      if (awaited_q.size() == 0) begin
         if (report_due())
            $display("slot table: unexpected result, got %s", fmt_rsp(got));
         return;
      end
      want = awaited_q.pop_front();
      if (got.status !== want.status || got.slot_index !== want.slot_index ||
          got.dispatched_handler !== want.dispatched_handler ||
          got.handler_count !== want.handler_count ||
          got.is_dispatch !== want.is_dispatch || got.last !== want.last) begin
         if (report_due()) begin
            $display("slot table: result mismatch");
            $display("   expected %s", fmt_rsp(want));
            $display("   actual   %s", fmt_rsp(got));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         awaited_q.delete();
         foreach (slot_store[s, k])
            slot_store[s][k] = '0;
         mismatch_count = 0;
      end else begin
         // results first, so a result can never match a request taken in the same cycle
         if (rsp_valid && rsp_ready)
            check_result(rsp_data);
         if (req_valid && req_ready)
            apply_command(req_data);
      end
      awaited_count <= awaited_q.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top: drives slot table requests and result stalls, and gives the verdict
`timescale 1ns / 100ps
module tb;

   localparam int          RUN_LIMIT   = 400_000;
   localparam int          TAIL_CYCLES = 40;
   localparam logic [1:0]  CMD_UNUSED  = 2'd3;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   eht_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   eht_pkg::rsp_type rsp_data;

   int          mismatch_count;
   int          awaited_count;
   bit          calm = 1'b0;
   int unsigned real_items = 0;

   event_handler_slot_table_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   eht_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic eht_pkg::req_type req_of(logic [1:0] cmd, int unsigned sig,
                                               logic [15:0] hid);
      eht_pkg::req_type r;
      r.command       = cmd;
      r.signal_number = sig[3:0];
      r.handler_id    = hid;
      return r;
   endfunction

   task automatic send_item(eht_pkg::req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (item.command inside {eht_pkg::CMD_ADD, eht_pkg::CMD_REMOVE, eht_pkg::CMD_TRIGGER})
         real_items++;
   endtask

   task automatic hold_off(int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_gap();
      if (!calm && $urandom_range(0, 3) == 0)
         hold_off($urandom_range(1, 7));
   endtask

   // sender waits until every queued result has come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_count != 0);
   endtask

   // result side stalls in short bursts, with occasional long stretches of none
   initial begin
      @(posedge clock);
      forever begin
         if (calm || $urandom_range(0, 2) != 0) begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 60 : 10))
               @(posedge clock);
         end else begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end
      end
   end

   initial begin
      repeat (RUN_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   initial begin
      logic [15:0]      pool [6];
      int unsigned      rows [4];
      int unsigned      start;
      int unsigned      pick;
      logic [1:0]       cmd;
      logic [31:0]      noise;
      eht_pkg::req_type item;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty row, extreme ids and rows, zero handler, not found
      send_item(req_of(eht_pkg::CMD_TRIGGER, 0, 16'h0000));
      send_item(req_of(eht_pkg::CMD_ADD, 15, 16'hFFFF));
      maybe_gap();
      send_item(req_of(eht_pkg::CMD_ADD, 15, 16'h0001));
      send_item(req_of(eht_pkg::CMD_TRIGGER, 15, 16'h1234));
      send_item(req_of(eht_pkg::CMD_ADD, 2, 16'h0000));
      send_item(req_of(eht_pkg::CMD_REMOVE, 2, 16'h0000));
      send_item(req_of(eht_pkg::CMD_REMOVE, 2, 16'h5A5A));
      // fill a row, overflow it, dispatch all eight
      for (int i = 0; i < 8; i++) begin
         maybe_gap();
         send_item(req_of(eht_pkg::CMD_ADD, 3, 16'h1000 + 16'(i)));
      end
      send_item(req_of(eht_pkg::CMD_ADD, 3, 16'hBEEF));
      send_item(req_of(eht_pkg::CMD_TRIGGER, 3, 16'h0000));
      send_item(req_of(eht_pkg::CMD_REMOVE, 3, 16'h1004));
      send_item(req_of(eht_pkg::CMD_ADD, 3, 16'h8000));
      send_item(req_of(CMD_UNUSED, 5, 16'h0042));
      // duplicate handler in one row: remove takes the lowest slot
      send_item(req_of(eht_pkg::CMD_ADD, 7, 16'h00AA));
      send_item(req_of(eht_pkg::CMD_ADD, 7, 16'h00AA));
      send_item(req_of(eht_pkg::CMD_REMOVE, 7, 16'h00AA));
      send_item(req_of(eht_pkg::CMD_TRIGGER, 7, 16'hFFFF));
      drain();

      // random phases: small handler pool on a few rows, plus raw noise
      for (int ph = 0; ph < 4; ph++) begin
         foreach (pool[k])
            pool[k] = 16'($urandom_range(1, 16'hFFFF));
         foreach (rows[k])
            rows[k] = $urandom_range(0, eht_pkg::NUM_SIGNALS_DEF - 1);
         calm  = (ph == 3);
         start = real_items;
         while (real_items < start + 100) begin
            maybe_gap();
            if ($urandom_range(0, 9) < 7) begin
               pick = $urandom_range(0, 99);
               cmd  = (pick < 45) ? eht_pkg::CMD_ADD :
                      (pick < 80) ? eht_pkg::CMD_REMOVE : eht_pkg::CMD_TRIGGER;
               send_item(req_of(cmd, rows[$urandom_range(0, 3)], pool[$urandom_range(0, 5)]));
            end else begin
               noise = $urandom;
               item  = eht_pkg::req_type'(noise[21:0]);
               if ($urandom_range(0, 7) == 0)
                  item.handler_id = '0;
               send_item(item);
            end
         end
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
